FILE: sv/crtc_pkg.sv
// Shared types and constants for the CRTC timing register encoder.
// Holds the register numbering, pixel format codes and the encoded field record.
// No dependencies.
package crtc_pkg;

  localparam int NUM_REGS = 33;

  // Register numbers in emission order.
  localparam logic [5:0] CR_H_TOTAL         = 6'd0;
  localparam logic [5:0] CR_H_DISP_END      = 6'd1;
  localparam logic [5:0] CR_H_BLANK_START   = 6'd2;
  localparam logic [5:0] CR_H_BLANK_END     = 6'd3;
  localparam logic [5:0] CR_H_RETRACE_START = 6'd4;
  localparam logic [5:0] CR_H_RETRACE_END   = 6'd5;
  localparam logic [5:0] CR_V_TOTAL         = 6'd6;
  localparam logic [5:0] CR_OVERFLOW        = 6'd7;
  localparam logic [5:0] CR_PRESET_ROW      = 6'd8;
  localparam logic [5:0] CR_MAX_SCAN        = 6'd9;
  localparam logic [5:0] CR_CURSOR_START    = 6'd10;
  localparam logic [5:0] CR_CURSOR_END      = 6'd11;
  localparam logic [5:0] CR_START_HI        = 6'd12;
  localparam logic [5:0] CR_START_LO        = 6'd13;
  localparam logic [5:0] CR_CURSOR_HI       = 6'd14;
  localparam logic [5:0] CR_CURSOR_LO       = 6'd15;
  localparam logic [5:0] CR_V_RETRACE_START = 6'd16;
  localparam logic [5:0] CR_V_RETRACE_END   = 6'd17;
  localparam logic [5:0] CR_V_DISP_END      = 6'd18;
  localparam logic [5:0] CR_OFFSET          = 6'd19;
  localparam logic [5:0] CR_UNDERLINE       = 6'd20;
  localparam logic [5:0] CR_V_BLANK_START   = 6'd21;
  localparam logic [5:0] CR_V_BLANK_END     = 6'd22;
  localparam logic [5:0] CR_MODE_CTRL       = 6'd23;
  localparam logic [5:0] CR_LINE_COMPARE    = 6'd24;
  localparam logic [5:0] XR_CRT_OVERFLOW    = 6'd25;
  localparam logic [5:0] XR_H_OVERFLOW      = 6'd26;
  localparam logic [5:0] XR_V_OVERFLOW      = 6'd27;
  localparam logic [5:0] XR_H_OVERFLOW1     = 6'd28;
  localparam logic [5:0] XR_H_OVERFLOW2     = 6'd29;
  localparam logic [5:0] XR_PITCH           = 6'd30;
  localparam logic [5:0] XR_START_HI        = 6'd31;
  localparam logic [5:0] XR_LINE_WIDTH      = 6'd32;
  localparam logic [5:0] REG_LAST           = XR_LINE_WIDTH;

  // Fixed register contents.
  localparam logic [9:0]  LINE_COMPARE     = 10'h3ff;
  localparam logic [7:0]  CURSOR_START_VAL = 8'h20;
  localparam logic [7:0]  UNDERLINE_VAL    = 8'h40;
  localparam logic [7:0]  MODE_CTRL_VAL    = 8'he3;
  localparam logic [7:0]  LINE_WIDTH_VAL   = 8'(640 / 4);
  localparam logic [15:0] DSCAN_LIMIT      = 16'd300;
  localparam logic [9:0]  VARIANT_SHIFT    = 10'd5;

  typedef enum logic [1:0] {
    PIX_RGB32    = 2'd0,
    PIX_RGB16    = 2'd1,
    PIX_INDEXED8 = 2'd2,
    PIX_OTHER    = 2'd3
  } pix_fmt_t;

  // Only the bits that reach some register byte are kept.
  typedef struct packed {
    logic [9:0]  h_tot;
    logic [9:0]  h_de;
    logic [9:0]  h_bs;
    logic [7:0]  h_be;
    logic [9:0]  h_ss;
    logic [5:0]  h_re;
    logic [10:0] v_tot;
    logic [10:0] v_ss;
    logic [3:0]  v_re;
    logic [10:0] v_de;
    logic [7:0]  v_be;
    logic        dscan;
    logic [11:0] offs;
    logic [23:0] start_addr;
  } enc_fields_t;

endpackage

FILE: sv/crtc_req_if.sv
// Mode request channel: valid/ready handshake with the display timing fields.
// No dependencies.
interface crtc_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] h_active;
  logic [15:0] h_sync_on;
  logic [15:0] h_sync_off;
  logic [15:0] h_total;
  logic [15:0] v_active;
  logic [15:0] v_sync_on;
  logic [15:0] v_sync_off;
  logic [15:0] v_total;
  logic [1:0]  pixel_format;
  logic [15:0] row_pixels;
  logic [23:0] start_address;

  modport source (
    output valid, h_active, h_sync_on, h_sync_off, h_total,
           v_active, v_sync_on, v_sync_off, v_total,
           pixel_format, row_pixels, start_address,
    input  ready
  );

  modport sink (
    input  valid, h_active, h_sync_on, h_sync_off, h_total,
           v_active, v_sync_on, v_sync_off, v_total,
           pixel_format, row_pixels, start_address,
    output ready
  );
endinterface

FILE: sv/crtc_rsp_if.sv
// Register byte channel: valid/ready handshake with register number, value and last.
// No dependencies.
interface crtc_rsp_if;
  logic       valid;
  logic       ready;
  logic [5:0] reg_number;
  logic [7:0] reg_value;
  logic       last;

  modport source (output valid, reg_number, reg_value, last, input ready);
  modport sink (input valid, reg_number, reg_value, last, output ready);
endinterface

FILE: sv/crtc_timing_register_encoder.sv
// Top level of the CRTC timing register encoder.
// Depends on crtc_pkg, crtc_req_if, crtc_rsp_if, crtc_front, crtc_fifo and crtc_back.
//
// Usage:
//   req carries one display mode request per transfer (valid/ready). rsp carries
//   the resulting 33 register bytes in register order, 0x00..0x18 then the eight
//   extended bytes, with last set on register 32.
//   cfg_wr_en/cfg_wr_data write the single variant_630 bit; write it only while
//   no request is in flight. It is sampled when a request is transferred.
// First byte: with the back end idle, the request transfer edge writes the queue
//   and the next edge loads the output register with the first byte.
// Throughput: one register byte per cycle while rsp.ready stays high, set by the
//   back-end sequencer that reads one byte of the queue head each cycle.
//   The front end takes a new request while the back end still emits the
//   previous one; the two-entry queue holds up to two requests.
// Reset: rst clears the queue, the sequencer, the output valid and variant_630.
// Stall: when rsp.ready is low the output register holds its byte, the
//   sequencer waits, and once the queue fills req.ready drops.
module crtc_timing_register_encoder
  import crtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  crtc_req_if.sink   req,
  crtc_rsp_if.source rsp
);

  logic        push_valid;
  logic        push_ready;
  enc_fields_t push_data;
  logic        head_valid;
  logic        pop;
  enc_fields_t head_data;

  crtc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  crtc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  crtc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

FILE: sv/crtc_front.sv
// Front end: accepts mode requests and works out the CRTC timing fields.
// Depends on crtc_pkg and crtc_req_if; holds the variant_630 register.
module crtc_front
  import crtc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  crtc_req_if.sink     req,
  output logic         push_valid,
  input  logic         push_ready,
  output enc_fields_t  push_data
);

  logic        variant_630;
  logic [12:0] hvis;
  logic [15:0] hfront_d;
  logic [15:0] hsync_d;
  logic [15:0] hback_d;
  logic [12:0] hfront;
  logic [12:0] hsync;
  logic [12:0] hback;
  logic [15:0] vt_m2;
  logic        dscan;
  logic [11:0] offs;
  pix_fmt_t    fmt;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant_630 <= 1'b0;
    end else if (cfg_wr_en) begin
      variant_630 <= cfg_wr_data;
    end
  end

  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  assign hvis     = req.h_active[15:3];
  assign hfront_d = req.h_sync_on - req.h_active;
  assign hsync_d  = req.h_sync_off - req.h_sync_on;
  assign hback_d  = req.h_total - req.h_sync_off;
  assign hfront   = hfront_d[15:3];
  assign hsync    = hsync_d[15:3];
  assign hback    = hback_d[15:3];

  // A total of 0 or 1 wraps far above the limit, so it never double scans.
  assign vt_m2 = req.v_total - 16'd2;
  assign dscan = (req.v_total >= 16'd2) && (vt_m2 < DSCAN_LIMIT);

  assign fmt = pix_fmt_t'(req.pixel_format);

  always_comb begin
    unique case (fmt)
      PIX_RGB32:    offs = req.row_pixels[12:1];
      PIX_RGB16:    offs = req.row_pixels[13:2];
      PIX_INDEXED8: offs = req.row_pixels[14:3];
      PIX_OTHER:    offs = 12'd0;
      default:      offs = 12'd0;
    endcase
  end

  always_comb begin
    push_data.h_tot = req.h_total[12:3] - 10'd5;
    push_data.h_de  = {2'b00, hvis[7:0]} - 10'd1;
    push_data.h_bs  = hvis[9:0] - 10'd1;
    push_data.h_be  = hvis[7:0] + hfront[7:0] + hsync[7:0] + hback[7:0] - 8'd1;
    push_data.h_ss  = hvis[9:0] + hfront[9:0] - 10'd1
                      + (variant_630 ? VARIANT_SHIFT : 10'd0);
    push_data.h_re  = hvis[5:0] + hfront[5:0] + hsync[5:0] - 6'd1;
    push_data.v_tot = dscan ? {vt_m2[9:0], 1'b0} : vt_m2[10:0];
    push_data.v_ss  = req.v_sync_on[10:0] - 11'd1;
    push_data.v_re  = req.v_sync_off[3:0] - 4'd1;
    push_data.v_de  = req.v_active[10:0] - 11'd1;
    push_data.v_be  = req.v_total[7:0] - 8'd1;
    push_data.dscan = dscan;
    push_data.offs  = offs;
    push_data.start_addr = req.start_address;
  end

endmodule

FILE: sv/crtc_fifo.sv
// Two-entry queue of encoded field records between the front and back ends.
// Depends on crtc_pkg.
module crtc_fifo
  import crtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  enc_fields_t push_data,
  output logic        head_valid,
  input  logic        pop,
  output enc_fields_t head_data
);

  enc_fields_t mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count beyond depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

FILE: sv/crtc_back.sv
// Back end: emits the head record's 33 register bytes, one per unstalled cycle.
// Depends on crtc_pkg and crtc_rsp_if; the output register decouples the receiver.
module crtc_back
  import crtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  enc_fields_t head_data,
  output logic        pop,
  crtc_rsp_if.source  rsp
);

  logic [5:0] idx;
  logic       load;
  logic       at_last;
  logic [7:0] byte_val;
  logic       out_valid;
  logic [5:0] reg_number;
  logic [7:0] reg_value;
  logic       last;

  enc_fields_t f;
  assign f = head_data;

  assign load    = head_valid && (!out_valid || rsp.ready);
  assign at_last = (idx == REG_LAST);
  assign pop     = load && at_last;

  always_comb begin
    unique case (idx)
      CR_H_TOTAL:         byte_val = f.h_tot[7:0];
      CR_H_DISP_END:      byte_val = f.h_de[7:0];
      CR_H_BLANK_START:   byte_val = f.h_bs[7:0];
      CR_H_BLANK_END:     byte_val = {3'b100, f.h_be[4:0]};
      CR_H_RETRACE_START: byte_val = f.h_ss[7:0];
      CR_H_RETRACE_END:   byte_val = {f.h_be[5], 2'b00, f.h_re[4:0]};
      CR_V_TOTAL:         byte_val = f.v_tot[7:0];
      CR_OVERFLOW:        byte_val = {f.v_ss[9], f.v_de[9], f.v_tot[9], LINE_COMPARE[8],
                                      f.v_de[8], f.v_ss[8], f.v_de[8], f.v_tot[8]};
      CR_MAX_SCAN:        byte_val = {f.dscan, LINE_COMPARE[9], f.v_de[9], 5'b00000};
      CR_CURSOR_START:    byte_val = CURSOR_START_VAL;
      CR_START_HI:        byte_val = f.start_addr[15:8];
      CR_START_LO:        byte_val = f.start_addr[7:0];
      CR_V_RETRACE_START: byte_val = f.v_ss[7:0];
      CR_V_RETRACE_END:   byte_val = {4'b1000, f.v_re};
      CR_V_DISP_END:      byte_val = f.v_de[7:0];
      CR_OFFSET:          byte_val = f.offs[7:0];
      CR_UNDERLINE:       byte_val = UNDERLINE_VAL;
      CR_V_BLANK_START:   byte_val = f.v_de[7:0];
      CR_V_BLANK_END:     byte_val = f.v_be;
      CR_MODE_CTRL:       byte_val = MODE_CTRL_VAL;
      CR_LINE_COMPARE:    byte_val = LINE_COMPARE[7:0];
      XR_CRT_OVERFLOW:    byte_val = {f.offs[11:8], f.v_ss[10], f.v_de[10],
                                      f.v_de[10], f.v_tot[10]};
      XR_H_OVERFLOW:      byte_val = {3'b000, f.h_be[6], f.h_ss[8], f.h_bs[8],
                                      f.h_de[8], f.h_tot[8]};
      XR_V_OVERFLOW:      byte_val = {4'b0000, f.v_ss[10], f.v_de[10],
                                      f.v_de[10], f.v_tot[10]};
      XR_H_OVERFLOW1:     byte_val = {f.h_ss[9:8], f.h_bs[9:8], f.h_de[9:8], f.h_tot[9:8]};
      XR_H_OVERFLOW2:     byte_val = {5'b00000, f.h_re[5], f.h_be[7:6]};
      XR_PITCH:           byte_val = {4'b0000, f.offs[11:8]};
      XR_START_HI:        byte_val = f.start_addr[23:16];
      XR_LINE_WIDTH:      byte_val = LINE_WIDTH_VAL;
      // Preset row, cursor end and both cursor location bytes read as zero.
      default:            byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= CR_H_TOTAL;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx       <= at_last ? CR_H_TOTAL : idx + 6'd1;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reg_number <= idx;
      reg_value  <= byte_val;
      last       <= at_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.reg_number = reg_number;
  assign rsp.reg_value  = reg_value;
  assign rsp.last       = last;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= REG_LAST)
    else $error("register index out of range");

  a_last_number: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (reg_number == REG_LAST)))
    else $error("last flag does not match final register");

  a_number_step: assert property (@(posedge clk) disable iff (rst)
    ($past(out_valid && rsp.ready && !last) && out_valid)
      |-> (reg_number == $past(reg_number) + 6'd1))
    else $error("register numbers out of sequence");

  a_pop_at_end: assert property (@(posedge clk) disable iff (rst)
    pop |=> (idx == CR_H_TOTAL))
    else $error("record released before its last byte");

endmodule

FILE: sim/crtc_timing_register_encoder_test.sv
// Testbench for crtc_timing_register_encoder: sends display mode requests and checks
// the 33 register bytes of each one against a scoreboard that computes them itself.
// Depends on crtc_pkg, crtc_req_if, crtc_rsp_if and the encoder RTL.
module crtc_timing_register_encoder_test;
  import crtc_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int PHASE_ITEMS = 90;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [15:0] h_active;
    logic [15:0] h_sync_on;
    logic [15:0] h_sync_off;
    logic [15:0] h_total;
    logic [15:0] v_active;
    logic [15:0] v_sync_on;
    logic [15:0] v_sync_off;
    logic [15:0] v_total;
    pix_fmt_t    pixel_format;
    logic [15:0] row_pixels;
    logic [23:0] start_address;
  } mode_req_t;

  typedef struct packed {
    logic [5:0] number;
    logic [7:0] value;
    logic       last;
  } reg_byte_t;

  class crtc_byte_board;
    reg_byte_t expected_bytes[$];
    bit variant_630;
    int mismatches;
    int bytes_checked;
    int requests;

    // Works out the register bytes of one accepted mode request, in emission order.
    function void note_request(mode_req_t m);
      bit [31:0] hd, hss, hse, ht, vd, vss, vse, vt, row;
      bit [31:0] hvis, hfront, hsync, hback;
      bit [31:0] h_tot, h_de, h_bs, h_be, h_ss, h_re;
      bit [31:0] v_tot, v_ss, v_re, v_de, v_bs, v_be, offs;
      bit [23:0] sa;
      bit [9:0] lc;
      bit dscan;
      logic [7:0] regs [NUM_REGS];
      reg_byte_t b;
      hd = {16'd0, m.h_active};
      hss = {16'd0, m.h_sync_on};
      hse = {16'd0, m.h_sync_off};
      ht = {16'd0, m.h_total};
      vd = {16'd0, m.v_active};
      vss = {16'd0, m.v_sync_on};
      vse = {16'd0, m.v_sync_off};
      vt = {16'd0, m.v_total};
      row = {16'd0, m.row_pixels};
      sa = m.start_address;
      lc = LINE_COMPARE;

      // Horizontal values are in character clocks; all differences wrap at 32 bits.
      hvis = hd >> 3;
      hfront = (hss - hd) >> 3;
      hsync = (hse - hss) >> 3;
      hback = (ht - hse) >> 3;
      h_tot = (ht >> 3) - 32'd5;
      h_de = (hvis & 32'hff) - 32'd1;
      h_bs = hvis - 32'd1;
      h_be = (hvis + hfront + hsync + hback - 32'd1) & 32'hff;
      h_ss = hvis + hfront - 32'd1;
      h_re = (hvis + hfront + hsync - 32'd1) & 32'h3f;

      v_tot = vt - 32'd2;
      v_ss = vss - 32'd1;
      v_re = (vse - 32'd1) & 32'h0f;
      v_de = vd - 32'd1;
      v_bs = vd - 32'd1;
      v_be = (vt - 32'd1) & 32'hff;

      case (m.pixel_format)
        PIX_RGB32:    offs = row / 2;
        PIX_RGB16:    offs = row / 4;
        PIX_INDEXED8: offs = row / 8;
        default:      offs = 32'd0;
      endcase

      dscan = (v_tot < 32'd300);
      if (dscan) v_tot = v_tot << 1;
      if (variant_630) h_ss = h_ss + 32'd5;

      regs[CR_H_TOTAL]         = h_tot[7:0];
      regs[CR_H_DISP_END]      = h_de[7:0];
      regs[CR_H_BLANK_START]   = h_bs[7:0];
      regs[CR_H_BLANK_END]     = {3'b100, h_be[4:0]};
      regs[CR_H_RETRACE_START] = h_ss[7:0];
      regs[CR_H_RETRACE_END]   = {h_be[5], 2'b00, h_re[4:0]};
      regs[CR_V_TOTAL]         = v_tot[7:0];
      regs[CR_OVERFLOW]        = {v_ss[9], v_de[9], v_tot[9], lc[8],
                                  v_bs[8], v_ss[8], v_de[8], v_tot[8]};
      regs[CR_PRESET_ROW]      = 8'h00;
      regs[CR_MAX_SCAN]        = {dscan, lc[9], v_bs[9], 5'b00000};
      regs[CR_CURSOR_START]    = 8'h20;
      regs[CR_CURSOR_END]      = 8'h00;
      regs[CR_START_HI]        = sa[15:8];
      regs[CR_START_LO]        = sa[7:0];
      regs[CR_CURSOR_HI]       = 8'h00;
      regs[CR_CURSOR_LO]       = 8'h00;
      regs[CR_V_RETRACE_START] = v_ss[7:0];
      regs[CR_V_RETRACE_END]   = {4'b1000, v_re[3:0]};
      regs[CR_V_DISP_END]      = v_de[7:0];
      regs[CR_OFFSET]          = offs[7:0];
      regs[CR_UNDERLINE]       = 8'h40;
      regs[CR_V_BLANK_START]   = v_bs[7:0];
      regs[CR_V_BLANK_END]     = v_be[7:0];
      regs[CR_MODE_CTRL]       = 8'he3;
      regs[CR_LINE_COMPARE]    = lc[7:0];
      regs[XR_CRT_OVERFLOW]    = {offs[11:8], v_ss[10], v_bs[10], v_de[10], v_tot[10]};
      regs[XR_H_OVERFLOW]      = {3'b000, h_be[6], h_ss[8], h_bs[8], h_de[8], h_tot[8]};
      regs[XR_V_OVERFLOW]      = {2'b00, v_re[4], v_be[8], v_ss[10], v_bs[10],
                                  v_de[10], v_tot[10]};
      regs[XR_H_OVERFLOW1]     = {h_ss[9:8], h_bs[9:8], h_de[9:8], h_tot[9:8]};
      regs[XR_H_OVERFLOW2]     = {5'b00000, h_re[5], h_be[7:6]};
      regs[XR_PITCH]           = {4'b0000, offs[11:8]};
      regs[XR_START_HI]        = sa[23:16];
      regs[XR_LINE_WIDTH]      = 8'd160;

      for (int k = 0; k < NUM_REGS; k++) begin
        b.number = k[5:0];
        b.value = regs[k];
        b.last = (k[5:0] == REG_LAST);
        expected_bytes.push_back(b);
      end
      requests++;
    endfunction

    function void check_byte(reg_byte_t got);
      reg_byte_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected register byte: number %0d value 0x%02h last %0b",
                   got.number, got.value, got.last);
      end else begin
        want = expected_bytes.pop_front();
        bytes_checked++;
        if (got.number !== want.number || got.value !== want.value ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: byte %0d: expected number %0d value 0x%02h last %0b,",
                     bytes_checked, want.number, want.value, want.last,
                     " got number %0d value 0x%02h last %0b",
                     got.number, got.value, got.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  bit   steady_flow;
  int   variant_writes;

  crtc_req_if req_ch();
  crtc_rsp_if rsp_ch();
  crtc_byte_board board;

  crtc_timing_register_encoder u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic mode_req_t make_mode(int hd, int hss, int hse, int ht,
                                          int vd, int vss, int vse, int vt,
                                          pix_fmt_t fmt, int row, int sa);
    mode_req_t m;
    m.h_active = 16'(hd);
    m.h_sync_on = 16'(hss);
    m.h_sync_off = 16'(hse);
    m.h_total = 16'(ht);
    m.v_active = 16'(vd);
    m.v_sync_on = 16'(vss);
    m.v_sync_off = 16'(vse);
    m.v_total = 16'(vt);
    m.pixel_format = fmt;
    m.row_pixels = 16'(row);
    m.start_address = 24'(sa);
    return m;
  endfunction

  // Mostly ordered timings with random spacing; a quarter are raw noise.
  function automatic mode_req_t random_mode();
    mode_req_t m;
    if ($urandom_range(0, 3) == 0) begin
      m = make_mode($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, pix_fmt_t'($urandom_range(0, 3)),
                    $urandom, $urandom);
    end else begin
      m.h_active = 16'($urandom_range(0, 4095));
      m.h_sync_on = m.h_active + 16'($urandom_range(0, 127));
      m.h_sync_off = m.h_sync_on + 16'($urandom_range(0, 255));
      m.h_total = m.h_sync_off + 16'($urandom_range(0, 511));
      m.v_active = 16'($urandom_range(0, 2047));
      m.v_sync_on = m.v_active + 16'($urandom_range(0, 63));
      m.v_sync_off = m.v_sync_on + 16'($urandom_range(0, 31));
      m.v_total = m.v_sync_off + 16'($urandom_range(0, 63));
      m.pixel_format = pix_fmt_t'($urandom_range(0, 3));
      m.row_pixels = 16'($urandom);
      m.start_address = 24'($urandom);
    end
    return m;
  endfunction

  task automatic send_mode(input mode_req_t m);
    while (!steady_flow && $urandom_range(0, 99) < 18) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.h_active <= m.h_active;
    req_ch.h_sync_on <= m.h_sync_on;
    req_ch.h_sync_off <= m.h_sync_off;
    req_ch.h_total <= m.h_total;
    req_ch.v_active <= m.v_active;
    req_ch.v_sync_on <= m.v_sync_on;
    req_ch.v_sync_off <= m.v_sync_off;
    req_ch.v_total <= m.v_total;
    req_ch.pixel_format <= m.pixel_format;
    req_ch.row_pixels <= m.row_pixels;
    req_ch.start_address <= m.start_address;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(m);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (board.expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_variant(input bit v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.variant_630 = v;
    variant_writes++;
  endtask

  // Result side: random back-pressure except during the steady stretch.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 18);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_byte({rsp_ch.reg_number, rsp_ch.reg_value, rsp_ch.last});
  end

  initial begin
    int directed_count;
    board = new();
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.h_active <= '0;
    req_ch.h_sync_on <= '0;
    req_ch.h_sync_off <= '0;
    req_ch.h_total <= '0;
    req_ch.v_active <= '0;
    req_ch.v_sync_on <= '0;
    req_ch.v_sync_off <= '0;
    req_ch.v_total <= '0;
    req_ch.pixel_format <= PIX_RGB32;
    req_ch.row_pixels <= '0;
    req_ch.start_address <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed modes with the register at its reset value.
    send_mode(make_mode(640, 656, 752, 800, 480, 490, 492, 525, PIX_INDEXED8, 640, 0));
    send_mode(make_mode(0, 0, 0, 0, 0, 0, 0, 0, PIX_RGB32, 0, 0));
    send_mode(make_mode(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff, 16'hffff, PIX_OTHER, 16'hffff, 24'hffffff));
    send_mode(make_mode(800, 840, 968, 1056, 600, 601, 605, 628, PIX_RGB16, 800,
                        24'h123456));
    // Vertical totals right below and at the double scan limit.
    send_mode(make_mode(320, 328, 376, 400, 200, 206, 208, 301, PIX_RGB32, 320,
                        24'habcdef));
    send_mode(make_mode(320, 328, 376, 400, 200, 206, 208, 302, PIX_RGB32, 320,
                        24'h000001));
    // Totals of one and zero wrap below the offsets taken off them.
    send_mode(make_mode(640, 656, 752, 800, 480, 490, 492, 1, PIX_RGB16, 1024, 24'h800000));
    send_mode(make_mode(8, 16, 24, 8, 1, 1, 0, 0, PIX_INDEXED8, 8, 24'h7fffff));
    // A display count of 256 character clocks makes the display end all ones.
    send_mode(make_mode(2048, 2056, 2100, 2200, 1536, 1540, 1545, 1600, PIX_RGB32,
                        16'hfffe, 24'h00ff00));
    // Counts out of order.
    send_mode(make_mode(1000, 500, 400, 300, 900, 800, 700, 600, PIX_RGB16, 16'h8001,
                        24'hff00ff));
    send_mode(make_mode(1920, 2008, 2052, 2200, 2000, 2047, 2063, 2100, PIX_INDEXED8,
                        16'hffff, 24'h0f0f0f));
    send_mode(make_mode(640, 656, 752, 800, 480, 490, 492, 525, PIX_OTHER, 4096, 24'h555555));
    wait_drained();
    write_variant(1'b1);
    send_mode(make_mode(640, 656, 752, 800, 480, 490, 492, 525, PIX_INDEXED8, 640, 0));
    send_mode(make_mode(2040, 2044, 2100, 2200, 768, 771, 777, 806, PIX_RGB32, 1024,
                        24'haaaaaa));
    send_mode(make_mode(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                        16'hffff, 16'hffff, PIX_OTHER, 16'hffff, 24'hffffff));
    directed_count = board.requests;

    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      write_variant(phase[0]);
      steady_flow = (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Hold the sender once until every outstanding byte has come out.
        if (phase == 2 && n == PHASE_ITEMS / 2) wait_drained();
        send_mode(random_mode());
      end
    end
    steady_flow = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    if (board.expected_bytes.size() != 0)
      $display("ERROR: %0d expected register bytes never arrived",
               board.expected_bytes.size());
    $display("Covered %0d mode requests (%0d directed) with %0d register bytes checked,",
             board.requests, directed_count, board.bytes_checked);
    $display("across %0d variant register writes; %0d mismatches found.",
             variant_writes, board.mismatches);
    if (board.mismatches == 0 && board.expected_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("ERROR: timeout with %0d register bytes outstanding",
             board.expected_bytes.size());
    $display("FAIL");
    $finish;
  end

endmodule
